### rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// Allpass chain reverb package
// Shared widths, register codes, reset values and fixed-point helpers for
// the reverb pipeline and its delay stages.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int STAGES_DEF      = 4;
   localparam int LINE_DEPTH_DEF  = 4096;
   localparam int BASE_LENGTH_DEF = 1200;
   localparam int LENGTH_STEP_DEF = 800;
   localparam int MAX_LENGTH      = 4800;

   localparam int SAMPLE_W    = 25;
   localparam int WIDE_W      = 26;
   localparam int GAIN_W      = 17;
   localparam int FB_W        = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = GAIN_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;
   typedef logic        [GAIN_W-1:0]   gain_type;
   typedef logic        [FB_W-1:0]     fb_type;

   typedef struct packed {
      logic load;
      logic act;
      logic wr;
   } stage_ctrl_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_REVERB_ON = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WET_MIX   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOM_SIZE = CSR_INDEX_W'(3);

   localparam gain_type GAIN_ONE        = 17'd65536;
   localparam gain_type WET_MIX_RESET   = 17'd0;
   localparam gain_type DAMPING_RESET   = 17'd32768;
   localparam gain_type ROOM_SIZE_RESET = 17'd32768;
   localparam logic [15:0] FB_SCALE     = 16'd45875;

   localparam wide_type   WIDE_TWO       = 26'sd8388608;
   localparam wide_type   WIDE_NEG_TWO   = -26'sd8388608;
   localparam sample_type SAMPLE_TWO     = 25'sd8388608;
   localparam sample_type SAMPLE_NEG_TWO = -25'sd8388608;

   function automatic sample_type clamp2(input wide_type v);
      sample_type r;
      if (v > WIDE_TWO) begin
         r = SAMPLE_TWO;
      end else if (v < WIDE_NEG_TWO) begin
         r = SAMPLE_NEG_TWO;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   function automatic gain_type sat_gain(input gain_type g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

   // Feedback gain is the damping gain times 0.7, rounded half up.
   function automatic fb_type fb_of(input gain_type damping);
      logic [32:0] p;
      p = 33'(sat_gain(damping)) * 33'(FB_SCALE) + 33'd32768;
      return p[31:16];
   endfunction

   function automatic int stage_len(input int base, input int step, input int idx,
                                    input int depth);
      int len;
      len = base + step * idx;
      if (len > MAX_LENGTH) len = MAX_LENGTH;
      if (len > depth) len = depth;
      if (len < 1) len = 1;
      return len;
   endfunction

endpackage

### rtl/acr_stage.sv
// ----------------------------------------------------------------------------
// Allpass delay stage
// One stage of the chain: reads its delayed sample when a beat enters the
// stage slot, forms the output and the feedback value, and writes the line
// when the beat leaves the slot.
// ----------------------------------------------------------------------------
module acr_stage import acr_pkg::*; #(
   parameter int LEN   = 1200,
   parameter int DEPTH = LINE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  stage_ctrl_type ctrl,
   input  sample_type     x_in,
   input  fb_type         fb,
   output wide_type       y_out
);

   sample_type         d;
   logic signed [41:0] prod;
   logic signed [41:0] prod_rnd;
   wide_type           df;
   wide_type           w;
   sample_type         w_sat;

   always_comb begin
      prod     = 42'(d) * $signed({26'd0, fb});
      prod_rnd = prod + 42'sd32768;
      df       = prod_rnd[41:16];
      y_out    = WIDE_W'(x_in) + df;
      w        = WIDE_W'(x_in) - df;
      w_sat    = clamp2(w);
   end

   generate
      if (LEN == 1) begin : g_reg
         sample_type last_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               last_ff <= '0;
            end else if (ctrl.wr) begin
               last_ff <= w_sat;
            end
         end

         assign d = last_ff;
      end else begin : g_mem
         localparam int AW = $clog2(DEPTH);
         localparam logic [AW-1:0] LAST = AW'(LEN - 1);

         sample_type    mem [DEPTH];
         logic [AW-1:0] pos_ff;
         logic [AW-1:0] pos_in;
         logic          lap_ff;
         logic          lap_in;
         logic [AW-1:0] wa_ff;
         sample_type    rd_ff;
         logic          seen_ff;

         always_comb begin
            pos_in = pos_ff;
            lap_in = lap_ff;
            if (ctrl.load && ctrl.act) begin
               if (pos_ff == LAST) begin
                  pos_in = '0;
                  lap_in = 1'b1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               pos_ff <= '0;
               lap_ff <= 1'b0;
            end else begin
               pos_ff <= pos_in;
               lap_ff <= lap_in;
            end
         end

         // Entries of the first lap were never written and read as zero.
         always_ff @(posedge clock) begin
            if (ctrl.load) begin
               rd_ff   <= mem[pos_ff];
               wa_ff   <= pos_ff;
               seen_ff <= lap_ff;
            end
            if (ctrl.wr) begin
               mem[wa_ff] <= w_sat;
            end
         end

         assign d = seen_ff ? rd_ff : '0;

         a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
            ctrl.load && ctrl.act && ctrl.wr |-> wa_ff != pos_ff)
            else $error("Line read and write collide on one address.");

         a_pos_range: assert property (@(posedge clock) disable iff (reset)
            pos_ff <= LAST)
            else $error("Line position beyond stage length.");

         a_lap_holds: assert property (@(posedge clock) disable iff (reset)
            $past(lap_ff) && !$past(reset) |-> lap_ff)
            else $error("Line fill mark dropped without reset.");
      end
   endgenerate

endmodule

### rtl/allpass_chain_reverb_unit.sv
// ----------------------------------------------------------------------------
// Allpass chain reverb unit
// Stereo reverb: the mono average runs through a chain of allpass-like
// delay stages, the wet sums are scaled and crossfaded with the dry pair.
// ----------------------------------------------------------------------------
// Throughput is one beat per cycle while rsp_ready does not stall the result;
// back-pressure holds the beats in their slots and can drop req_ready.
// The rate is set by each stage's multiply, add and line write per beat.
// Reset is synchronous: it empties the pipeline and restores the registers.
// Delay lines read as zero until a stage's position has wrapped once, so no
// clearing pass is run and beats are taken right after reset.
module allpass_chain_reverb_unit import acr_pkg::*; #(
   parameter int STAGES      = STAGES_DEF,
   parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
   parameter int BASE_LENGTH = BASE_LENGTH_DEF,
   parameter int LENGTH_STEP = LENGTH_STEP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sample_type             req_in_left,
   input  sample_type             req_in_right,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sample_type             rsp_out_left,
   output sample_type             rsp_out_right,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PRD   = STAGES + 1;
   localparam int WET   = STAGES + 2;
   localparam int MIX   = STAGES + 3;
   localparam int OUT   = STAGES + 4;
   localparam int NSLOT = STAGES + 5;

   function automatic sample_type sat25(input logic signed [27:0] v);
      sample_type r;
      if (v > 28'sd16777215) begin
         r = 25'sd16777215;
      end else if (v < -28'sd16777216) begin
         r = -25'sd16777216;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   logic     reverb_on_ff;
   gain_type wet_mix_ff;
   gain_type damping_ff;
   gain_type room_size_ff;
   fb_type   fb_ff;
   gain_type mix_sat;
   gain_type size_sat;
   gain_type dry_gain;
   logic     active;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverb_on_ff <= 1'b0;
         wet_mix_ff   <= WET_MIX_RESET;
         damping_ff   <= DAMPING_RESET;
         room_size_ff <= ROOM_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REVERB_ON: reverb_on_ff <= csr_wdata[0];
            CSR_WET_MIX:   wet_mix_ff   <= csr_wdata;
            CSR_DAMPING:   damping_ff   <= csr_wdata;
            CSR_ROOM_SIZE: room_size_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= fb_of(DAMPING_RESET);
      end else begin
         fb_ff <= fb_of(damping_ff);
      end
   end

   always_comb begin
      mix_sat  = sat_gain(wet_mix_ff);
      size_sat = sat_gain(room_size_ff);
      dry_gain = GAIN_ONE - mix_sat;
      active   = reverb_on_ff && (mix_sat != '0);
   end

   logic                v_ff [NSLOT];
   logic                en   [NSLOT];
   logic                vin  [NSLOT];
   sample_type          dry_l_ff [OUT];
   sample_type          dry_r_ff [OUT];
   sample_type          x_ff [STAGES];
   wide_type            sum_l_ff [STAGES+1];
   wide_type            sum_r_ff [STAGES+1];
   wide_type            y_w [STAGES];
   stage_ctrl_type      ctrl_w [STAGES];
   logic signed [43:0]  pl_ff;
   logic signed [43:0]  pr_ff;
   sample_type          wl_ff;
   sample_type          wr_ff;
   logic signed [42:0]  mdl_ff;
   logic signed [42:0]  mwl_ff;
   logic signed [42:0]  mdr_ff;
   logic signed [42:0]  mwr_ff;
   sample_type          rsp_out_left_ff;
   sample_type          rsp_out_right_ff;

   wide_type            lr_sum;
   sample_type          x0_in;
   logic signed [43:0]  pl_rnd;
   logic signed [43:0]  pr_rnd;
   sample_type          wl_in;
   sample_type          wr_in;
   logic signed [43:0]  ol_sum;
   logic signed [43:0]  or_sum;
   sample_type          rsp_out_left_in;
   sample_type          rsp_out_right_in;

   always_comb begin
      en[OUT] = !v_ff[OUT] || rsp_ready;
      for (int k = OUT - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      vin[0] = req_valid;
      for (int k = 1; k < NSLOT; k++) begin
         vin[k] = v_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         ctrl_w[k].load = en[k];
         ctrl_w[k].act  = vin[k] && active;
         ctrl_w[k].wr   = v_ff[k] && active && en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[OUT];

   always_comb begin
      lr_sum = WIDE_W'(req_in_left) + WIDE_W'(req_in_right);
      x0_in  = clamp2({lr_sum[WIDE_W-1], lr_sum[WIDE_W-1:1]});
      pl_rnd = pl_ff + 44'sd131072;
      pr_rnd = pr_ff + 44'sd131072;
      wl_in  = clamp2(pl_rnd[43:18]);
      wr_in  = clamp2(pr_rnd[43:18]);
      ol_sum = 44'(mdl_ff) + 44'(mwl_ff) + 44'sd32768;
      or_sum = 44'(mdr_ff) + 44'(mwr_ff) + 44'sd32768;
      rsp_out_left_in  = active ? sat25(ol_sum[43:16]) : dry_l_ff[MIX];
      rsp_out_right_in = active ? sat25(or_sum[43:16]) : dry_r_ff[MIX];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSLOT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NSLOT; k++) begin
            if (en[k]) begin
               v_ff[k] <= vin[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dry_l_ff[0] <= req_in_left;
         dry_r_ff[0] <= req_in_right;
         x_ff[0]     <= x0_in;
         sum_l_ff[0] <= '0;
         sum_r_ff[0] <= '0;
      end
      for (int k = 1; k < OUT; k++) begin
         if (en[k]) begin
            dry_l_ff[k] <= dry_l_ff[k-1];
            dry_r_ff[k] <= dry_r_ff[k-1];
         end
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            x_ff[k] <= clamp2(y_w[k-1]);
         end
      end
      for (int k = 1; k <= STAGES; k++) begin
         if (en[k]) begin
            sum_l_ff[k] <= sum_l_ff[k-1] + ((k - 1 < 2) ? y_w[k-1] : '0);
            sum_r_ff[k] <= sum_r_ff[k-1] + ((k - 1 >= 2) ? y_w[k-1] : '0);
         end
      end
      if (en[PRD]) begin
         pl_ff <= 44'(sum_l_ff[STAGES]) * $signed({27'd0, size_sat});
         pr_ff <= 44'(sum_r_ff[STAGES]) * $signed({27'd0, size_sat});
      end
      if (en[WET]) begin
         wl_ff <= wl_in;
         wr_ff <= wr_in;
      end
      if (en[MIX]) begin
         mdl_ff <= 43'(dry_l_ff[WET]) * $signed({26'd0, dry_gain});
         mwl_ff <= 43'(wl_ff) * $signed({26'd0, mix_sat});
         mdr_ff <= 43'(dry_r_ff[WET]) * $signed({26'd0, dry_gain});
         mwr_ff <= 43'(wr_ff) * $signed({26'd0, mix_sat});
      end
      if (en[OUT]) begin
         rsp_out_left_ff  <= rsp_out_left_in;
         rsp_out_right_ff <= rsp_out_right_in;
      end
   end

   assign rsp_out_left  = rsp_out_left_ff;
   assign rsp_out_right = rsp_out_right_ff;

   generate
      for (genvar g = 0; g < STAGES; g++) begin : g_stage
         localparam int LEN = stage_len(BASE_LENGTH, LENGTH_STEP, g, LINE_DEPTH);

         acr_stage #(
            .LEN   (LEN),
            .DEPTH (LINE_DEPTH)
         ) u_stage (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl_w[g]),
            .x_in  (x_ff[g]),
            .fb    (fb_ff),
            .y_out (y_w[g])
         );
      end
   endgenerate

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("Accepted beat did not enter the first slot.");

   a_out_from_mix: assert property (@(posedge clock) disable iff (reset)
      v_ff[OUT] && !$past(v_ff[OUT]) && !$past(reset) |-> $past(v_ff[MIX]))
      else $error("Result beat appeared without a beat in the mix slot.");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !en[1] |-> !req_ready)
      else $error("Request taken while the first slot is held.");

endmodule

### dv/tb_allpass_chain_reverb_unit.sv
// ----------------------------------------------------------------------------
// Allpass chain reverb unit testbench
// Drives stereo sample beats through the reverb with random idle and stall
// bursts, computes every processed pair with a cycle-free model of the stage
// chain, and compares each result beat field by field. Register settings
// cover bypass, over-range gains and the extremes.
// ----------------------------------------------------------------------------
module tb_allpass_chain_reverb_unit;
   import acr_pkg::*;

   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  DRAIN_CYCLES = 2 * (STAGES_DEF + 4);
   localparam int  HOLD_CYCLES  = 400;
   localparam int  GAIN_MAX     = (1 << GAIN_W) - 1;
   localparam int  INDEX_MAX    = (1 << CSR_INDEX_W) - 1;
   localparam longint SAT_HI    = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAT_LO    = -(longint'(1) << (SAMPLE_W - 1));
   localparam longint TWO_Q22   = longint'(1) << 23;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   sample_type             req_in_left = '0;
   sample_type             req_in_right = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sample_type             rsp_out_left;
   sample_type             rsp_out_right;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stereo_type  pairs_to_send[$];
   stereo_type  pairs_expected[$];
   stereo_type  send_pair;
   stereo_type  want_pair;
   sample_type  stage_taps [STAGES_DEF][LINE_DEPTH_DEF];
   int unsigned tap_pos [STAGES_DEF];
   logic        reverb_on_q;
   gain_type    wet_mix_q;
   gain_type    damping_q;
   gain_type    room_size_q;

   int  error_count = 0;
   int  beats_queued = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  reg_writes = 0;
   int  cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  hold_req = 1'b0;
   bit  idle_off = 1'b0;

   allpass_chain_reverb_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_left  (req_in_left),
      .req_in_right (req_in_right),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_left (rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint cap_gain(input gain_type g);
      return (g > GAIN_W'(65536)) ? 65536 : longint'(g);
   endfunction

   function automatic longint limit_two(input longint v);
      return (v > TWO_Q22) ? TWO_Q22 : ((v < -TWO_Q22) ? -TWO_Q22 : v);
   endfunction

   function automatic longint round_shift_up(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint saturate_out(input longint v);
      return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
   endfunction

   function automatic int unsigned tap_length(input int i);
      int len;
      len = BASE_LENGTH_DEF + LENGTH_STEP_DEF * i;
      if (len > MAX_LENGTH) len = MAX_LENGTH;
      if (len > LINE_DEPTH_DEF) len = LINE_DEPTH_DEF;
      if (len < 1) len = 1;
      return len;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_REVERB_ON: reverb_on_q = val[0];
         CSR_WET_MIX:   wet_mix_q = val;
         CSR_DAMPING:   damping_q = val;
         CSR_ROOM_SIZE: room_size_q = val;
         default: ;
      endcase
   endfunction

   function automatic void reverb_expect(input sample_type dry_l, input sample_type dry_r);
      longint      mix, fb, size, sum_l, sum_r, x, d, df, y, wet_l, wet_r, out_l, out_r;
      int unsigned len, p;
      stereo_type  res;
      mix = cap_gain(wet_mix_q);
      if (!reverb_on_q || mix == 0) begin
         res.left  = dry_l;
         res.right = dry_r;
      end else begin
         fb    = round_shift_up(cap_gain(damping_q) * longint'(FB_SCALE), 16);
         size  = cap_gain(room_size_q);
         sum_l = 0;
         sum_r = 0;
         x     = limit_two((longint'(dry_l) + longint'(dry_r)) >>> 1);
         for (int i = 0; i < STAGES_DEF; i++) begin
            len = tap_length(i);
            p   = tap_pos[i];
            if (p >= len) p = 0;
            d  = limit_two(longint'(stage_taps[i][p]));
            df = round_shift_up(d * fb, 16);
            y  = x + df;
            stage_taps[i][p] = sample_type'(limit_two(x - df));
            tap_pos[i] = (p + 1) % len;
            if (i < 2) sum_l += y;
            else sum_r += y;
            x = limit_two(y);
         end
         wet_l = limit_two(round_shift_up(sum_l * size, 18));
         wet_r = limit_two(round_shift_up(sum_r * size, 18));
         out_l = round_shift_up(longint'(dry_l) * (65536 - mix) + wet_l * mix, 16);
         out_r = round_shift_up(longint'(dry_r) * (65536 - mix) + wet_r * mix, 16);
         res.left  = sample_type'(saturate_out(out_l));
         res.right = sample_type'(saturate_out(out_r));
      end
      pairs_expected.push_back(res);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, pairs_expected.size());
         $display("FAIL");
         $finish;
      end
   end

   // Sender: holds a beat until accepted, otherwise idles in bursts or offers the next pair.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reverb_expect(req_in_left, req_in_right);
            beats_in++;
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pairs_to_send.size() != 0 && !idle_off &&
                         $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (pairs_to_send.size() != 0) begin
               send_pair = pairs_to_send.pop_front();
               req_valid    <= 1'b1;
               req_in_left  <= send_pair.left;
               req_in_right <= send_pair.right;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result beat against the oldest predicted pair.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (pairs_expected.size() == 0) begin
               report_error($sformatf("result beat with nothing pending, left %0d right %0d",
                                      rsp_out_left, rsp_out_right));
            end else begin
               want_pair = pairs_expected.pop_front();
               if (rsp_out_left !== want_pair.left)
                  report_error($sformatf("beat %0d out_left got %0d want %0d",
                                         beats_out, rsp_out_left, want_pair.left));
               if (rsp_out_right !== want_pair.right)
                  report_error($sformatf("beat %0d out_right got %0d want %0d",
                                         beats_out, rsp_out_right, want_pair.right));
            end
         end
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(idx, val);
      reg_writes++;
   endtask

   // Every queued pair must have come back before the registers change.
   task automatic settle();
      while (beats_out < beats_queued)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pair(input longint l, input longint r);
      stereo_type s;
      s.left  = sample_type'(l);
      s.right = sample_type'(r);
      pairs_to_send.push_back(s);
      beats_queued++;
   endtask

   function automatic longint pick_sample();
      case ($urandom_range(0, 9))
         0: return SAT_LO;
         1: return SAT_HI;
         2, 3: return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return longint'($urandom_range(0, (1 << SAMPLE_W) - 1)) + SAT_LO;
      endcase
   endfunction

   task automatic queue_extremes();
      queue_pair(SAT_LO, SAT_HI);
      queue_pair(SAT_HI, SAT_LO);
      queue_pair(SAT_HI, SAT_HI);
      queue_pair(0, -1);
   endtask

   task automatic run_phase(input int on_word, input int mix, input int damp,
                            input int room, input int count);
      settle();
      write_reg(CSR_REVERB_ON, CSR_DATA_W'(on_word));
      write_reg(CSR_WET_MIX, CSR_DATA_W'(mix));
      write_reg(CSR_DAMPING, CSR_DATA_W'(damp));
      write_reg(CSR_ROOM_SIZE, CSR_DATA_W'(room));
      repeat (count) queue_pair(pick_sample(), pick_sample());
   endtask

   initial begin
      foreach (stage_taps[i, j]) stage_taps[i][j] = '0;
      foreach (tap_pos[i]) tap_pos[i] = 0;
      reverb_on_q = 1'b0;
      wet_mix_q   = WET_MIX_RESET;
      damping_q   = DAMPING_RESET;
      room_size_q = ROOM_SIZE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: bypass at reset values, enable with zero mix, full wet with
      // over-range gains, zero gains, an unused register index and the smallest mix.
      queue_extremes();
      settle();
      write_reg(CSR_REVERB_ON, CSR_DATA_W'(1));
      queue_pair(SAT_HI, SAT_LO);
      queue_pair(-1, 1);
      settle();
      write_reg(CSR_WET_MIX, CSR_DATA_W'(65536));
      write_reg(CSR_DAMPING, CSR_DATA_W'(GAIN_MAX));
      write_reg(CSR_ROOM_SIZE, CSR_DATA_W'(GAIN_MAX));
      queue_extremes();
      queue_pair(SAT_LO, SAT_LO);
      queue_pair(1 << 22, 1 << 22);
      settle();
      write_reg(CSR_WET_MIX, CSR_DATA_W'(32768));
      write_reg(CSR_DAMPING, CSR_DATA_W'(0));
      write_reg(CSR_ROOM_SIZE, CSR_DATA_W'(0));
      queue_extremes();
      settle();
      write_reg(CSR_INDEX_W'($urandom_range(int'(CSR_ROOM_SIZE) + 1, INDEX_MAX)),
                CSR_DATA_W'($urandom_range(0, GAIN_MAX)));
      queue_pair(SAT_HI, 0);
      queue_pair(0, SAT_LO);
      queue_pair(-(1 << 23), 1 << 23);
      settle();
      write_reg(CSR_WET_MIX, CSR_DATA_W'(1));
      write_reg(CSR_ROOM_SIZE, CSR_DATA_W'(65536));
      queue_pair(SAT_HI, SAT_LO);
      queue_pair(SAT_LO, SAT_HI);
      queue_pair(12345, -54321);

      // Random part: random register settings and samples, with a long
      // receiver hold in the middle.
      run_phase(1, 65536, 65536, 65536, 200);
      repeat (4) begin
         run_phase($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                   $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX), 40);
      end
      run_phase(1, $urandom_range(1, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 65536), 60);
      @(posedge clock);
      hold_req <= 1'b1;
      run_phase(3, $urandom_range(1, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 65536), 100);
      run_phase(2, 65536, 65536, 65536, 20);
      settle();
      @(posedge clock);
      idle_off <= 1'b1;
      run_phase(1, GAIN_MAX, 0, 65536, 40);
      settle();

      if (pairs_expected.size() != 0)
         report_error($sformatf("%0d results never arrived", pairs_expected.size()));
      $display("Covered %0d input beats and %0d result beats over %0d register writes,",
               beats_in, beats_out, reg_writes);
      $display("including bypass, over-range gains, saturated samples and a long hold.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
